### rtl/core/bsl_pkg.sv
// Shared constants, token result type and helper functions of the byte stream lexer.
package bsl_pkg;

  localparam int OFFSET_BITS   = 32;
  localparam int KEYWORD_BYTES = 8;
  localparam int KW_IDX_BITS   = $clog2(KEYWORD_BYTES);
  localparam int KW_COUNT      = 8;
  localparam int KW_MAX_LEN    = 8;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [KEYWORD_BYTES-1:0][7:0] prefix_t;

  // token kinds
  localparam logic [5:0] K_PLUS   = 6'd0;
  localparam logic [5:0] K_MINUS  = 6'd1;
  localparam logic [5:0] K_STAR   = 6'd2;
  localparam logic [5:0] K_SLASH  = 6'd3;
  localparam logic [5:0] K_EQEQ   = 6'd4;
  localparam logic [5:0] K_EQ     = 6'd5;
  localparam logic [5:0] K_BANGEQ = 6'd6;
  localparam logic [5:0] K_LTEQ   = 6'd7;
  localparam logic [5:0] K_LT     = 6'd8;
  localparam logic [5:0] K_GTEQ   = 6'd9;
  localparam logic [5:0] K_GT     = 6'd10;
  localparam logic [5:0] K_ANDAND = 6'd11;
  localparam logic [5:0] K_AND    = 6'd12;
  localparam logic [5:0] K_OROR   = 6'd13;
  localparam logic [5:0] K_OR     = 6'd14;
  localparam logic [5:0] K_COLON  = 6'd15;
  localparam logic [5:0] K_COMMA  = 6'd16;
  localparam logic [5:0] K_LPAREN = 6'd17;
  localparam logic [5:0] K_RPAREN = 6'd18;
  localparam logic [5:0] K_LBRACE = 6'd19;
  localparam logic [5:0] K_RBRACE = 6'd20;
  localparam logic [5:0] K_SEMI   = 6'd21;
  localparam logic [5:0] K_EOF    = 6'd22;
  localparam logic [5:0] K_NUM    = 6'd23;
  localparam logic [5:0] K_KW0    = 6'd24;
  localparam logic [5:0] K_IDENT  = 6'd32;

  // error codes
  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_BANG     = 2'd1;
  localparam logic [1:0] E_OVERFLOW = 2'd2;
  localparam logic [1:0] E_BYTE     = 2'd3;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX_LEN] = '{
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", "c", "t", "i", "o", "n"},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd8, 4'd3, 4'd2, 4'd4, 4'd5, 4'd6
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  error_code;
    logic [30:0] number_value;
    logic [31:0] line_number;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        last_of_run;
  } token_t;

  function automatic offset_t off_inc(input offset_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] off_out(input offset_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic [5:0] word_kind(input prefix_t prefix, input logic [3:0] len);
    logic [5:0] kind;
    logic       same;
    kind = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      same = (len == KW_LEN[k]);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if ((4'(i) < KW_LEN[k]) && (prefix[i] != KW_CHARS[k][i])) same = 1'b0;
      end
      if (same) kind = K_KW0 + 6'(k);
    end
    return kind;
  endfunction

  function automatic token_t make_token(input logic [5:0] kind, input logic [1:0] err,
                                        input logic [30:0] val, input logic [31:0] line,
                                        input offset_t s, input offset_t e);
    token_t t;
    t.kind         = kind;
    t.error_code   = err;
    t.number_value = val;
    t.line_number  = line;
    t.start_offset = off_out(s);
    t.end_offset   = off_out(e);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

### rtl/core/bsl_if.sv
// Byte and token channel interfaces of the byte stream lexer.
interface bsl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source(output valid, output source_byte, input ready);
  modport sink(input valid, input source_byte, output ready);
endinterface

interface bsl_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [1:0]  error_code;
  logic [30:0] number_value;
  logic [31:0] line_number;
  logic [31:0] start_offset;
  logic [31:0] end_offset;
  logic        last_of_run;

  modport source(output valid, output kind, output error_code, output number_value,
                 output line_number, output start_offset, output end_offset,
                 output last_of_run, input ready);
  modport sink(input valid, input kind, input error_code, input number_value,
               input line_number, input start_offset, input end_offset,
               input last_of_run, output ready);
endinterface

### rtl/core/byte_stream_lexer_unit.sv
// Byte stream lexer top level: scanner state and token output queue.
//
// Takes one source byte per cycle and scans it against the current mode in a
// single pass; the zero, one or two tokens that the byte completes are written
// into a four-entry output queue and leave it in order on the token channel.
// A byte beat is taken whenever the queue has two free entries, so
// the block sustains one byte per cycle as long as the token side takes one
// token per cycle; a byte that completes two tokens adds one token to the
// queue backlog, which drains at one token per cycle. The last token caused by
// a byte carries last_of_run. A zero byte ends a source: it flushes any pending
// token, emits Eof and restarts line and offset counting.
module byte_stream_lexer_unit (
  input  logic             clk,
  input  logic             rst,
  bsl_byte_if.sink         bytes,
  bsl_token_if.source      tokens
);

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_NUM, MODE_WORD, MODE_EQ, MODE_BANG,
    MODE_LT, MODE_GT, MODE_AMP, MODE_PIPE
  } mode_t;

  mode_t                mode, mode_next;
  logic [30:0]          acc, acc_next;
  logic                 ovf, ovf_next;
  bsl_pkg::prefix_t     prefix, prefix_next;
  logic [3:0]           wlen, wlen_next;
  logic [31:0]          line, line_next;
  bsl_pkg::offset_t     off, off_next;
  bsl_pkg::offset_t     tstart, tstart_next;

  bsl_pkg::token_t      r0, r1;
  logic                 v0, v1;

  logic [7:0]           b;
  logic                 accept;
  logic                 is_digit, is_alpha;
  logic [34:0]          num_sum;
  logic                 do_idle;
  bsl_pkg::offset_t     e_byte;
  logic [7:0]           pair_byte;
  logic [5:0]           pair_kind, lone_kind;

  bsl_pkg::token_t      queue [4];
  logic [1:0]           wr_ptr, rd_ptr;
  logic [2:0]           count;
  logic                 pop;
  logic [1:0]           n_push;
  bsl_pkg::token_t      push_a, push_b;

  assign b        = bytes.source_byte;
  assign accept   = bytes.valid && bytes.ready;
  assign is_digit = (b inside {[8'h30:8'h39]});
  assign is_alpha = (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  assign num_sum  = 35'(acc) * 35'd10 + 35'(b[3:0]);
  assign e_byte   = bsl_pkg::off_inc(off);

  // second byte and kinds of the two-byte operators
  always_comb begin
    pair_byte = 8'h3D;
    pair_kind = bsl_pkg::K_EQEQ;
    lone_kind = bsl_pkg::K_EQ;
    case (mode)
      MODE_EQ: begin
        pair_kind = bsl_pkg::K_EQEQ;
        lone_kind = bsl_pkg::K_EQ;
      end
      MODE_BANG: begin
        pair_kind = bsl_pkg::K_BANGEQ;
        lone_kind = bsl_pkg::K_PLUS;
      end
      MODE_LT: begin
        pair_kind = bsl_pkg::K_LTEQ;
        lone_kind = bsl_pkg::K_LT;
      end
      MODE_GT: begin
        pair_kind = bsl_pkg::K_GTEQ;
        lone_kind = bsl_pkg::K_GT;
      end
      MODE_AMP: begin
        pair_byte = 8'h26;
        pair_kind = bsl_pkg::K_ANDAND;
        lone_kind = bsl_pkg::K_AND;
      end
      MODE_PIPE: begin
        pair_byte = 8'h7C;
        pair_kind = bsl_pkg::K_OROR;
        lone_kind = bsl_pkg::K_OR;
      end
      default: begin
        pair_byte = 8'h3D;
      end
    endcase
  end

  always_comb begin
    mode_next   = mode;
    acc_next    = acc;
    ovf_next    = ovf;
    prefix_next = prefix;
    wlen_next   = wlen;
    line_next   = line;
    off_next    = off;
    tstart_next = tstart;
    v0          = 1'b0;
    v1          = 1'b0;
    r0          = '0;
    r1          = '0;
    do_idle     = 1'b1;

    // flush or extend the pending token
    case (mode)
      MODE_NUM: begin
        if (is_digit) begin
          if (ovf || (num_sum > 35'(bsl_pkg::NUM_MAX))) ovf_next = 1'b1;
          else acc_next = num_sum[30:0];
          off_next = e_byte;
          do_idle  = 1'b0;
        end else begin
          v0 = 1'b1;
          if (ovf) begin
            r0 = bsl_pkg::make_token(bsl_pkg::K_NUM, bsl_pkg::E_OVERFLOW, 31'd0,
                                     line, tstart, off);
          end else begin
            r0 = bsl_pkg::make_token(bsl_pkg::K_NUM, bsl_pkg::E_NONE, acc,
                                     line, tstart, off);
          end
        end
      end
      MODE_WORD: begin
        if (is_digit || is_alpha) begin
          if ({1'b0, wlen} < 5'(bsl_pkg::KEYWORD_BYTES)) begin
            prefix_next[wlen[bsl_pkg::KW_IDX_BITS-1:0]] = b;
          end
          if (wlen != 4'hF) wlen_next = wlen + 4'd1;
          off_next = e_byte;
          do_idle  = 1'b0;
        end else begin
          v0 = 1'b1;
          r0 = bsl_pkg::make_token(bsl_pkg::word_kind(prefix, wlen), bsl_pkg::E_NONE,
                                   31'd0, line, tstart, off);
        end
      end
      MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_AMP, MODE_PIPE: begin
        v0 = 1'b1;
        if (b == pair_byte) begin
          r0 = bsl_pkg::make_token(pair_kind, bsl_pkg::E_NONE, 31'd0, line, tstart, e_byte);
          off_next  = e_byte;
          mode_next = MODE_IDLE;
          do_idle   = 1'b0;
        end else if (mode == MODE_BANG) begin
          r0 = bsl_pkg::make_token(bsl_pkg::K_PLUS, bsl_pkg::E_BANG, 31'd0, line, tstart, off);
        end else begin
          r0 = bsl_pkg::make_token(lone_kind, bsl_pkg::E_NONE, 31'd0, line, tstart, off);
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // scan the byte from idle
    if (do_idle) begin
      mode_next = MODE_IDLE;
      off_next  = e_byte;
      r1 = bsl_pkg::make_token(bsl_pkg::K_PLUS, bsl_pkg::E_NONE, 31'd0, line, off, e_byte);
      case (b)
        8'h00: begin
          v1        = 1'b1;
          r1.kind   = bsl_pkg::K_EOF;
          line_next = 32'd1;
          off_next  = '0;
        end
        8'h2B: begin v1 = 1'b1; r1.kind = bsl_pkg::K_PLUS;   end
        8'h2D: begin v1 = 1'b1; r1.kind = bsl_pkg::K_MINUS;  end
        8'h2A: begin v1 = 1'b1; r1.kind = bsl_pkg::K_STAR;   end
        8'h2F: begin v1 = 1'b1; r1.kind = bsl_pkg::K_SLASH;  end
        8'h3A: begin v1 = 1'b1; r1.kind = bsl_pkg::K_COLON;  end
        8'h2C: begin v1 = 1'b1; r1.kind = bsl_pkg::K_COMMA;  end
        8'h28: begin v1 = 1'b1; r1.kind = bsl_pkg::K_LPAREN; end
        8'h29: begin v1 = 1'b1; r1.kind = bsl_pkg::K_RPAREN; end
        8'h7B: begin v1 = 1'b1; r1.kind = bsl_pkg::K_LBRACE; end
        8'h7D: begin v1 = 1'b1; r1.kind = bsl_pkg::K_RBRACE; end
        8'h3B: begin v1 = 1'b1; r1.kind = bsl_pkg::K_SEMI;   end
        8'h3D: mode_next = MODE_EQ;
        8'h21: mode_next = MODE_BANG;
        8'h3C: mode_next = MODE_LT;
        8'h3E: mode_next = MODE_GT;
        8'h26: mode_next = MODE_AMP;
        8'h7C: mode_next = MODE_PIPE;
        default: begin
          if (b inside {8'h20, [8'h09:8'h0D]}) begin
            if ((b == 8'h0A) && (line != 32'hFFFF_FFFF)) line_next = line + 32'd1;
          end else if (is_digit) begin
            mode_next = MODE_NUM;
            acc_next  = 31'(b[3:0]);
            ovf_next  = 1'b0;
          end else if (is_alpha) begin
            mode_next   = MODE_WORD;
            prefix_next = '0;
            prefix_next[0] = b;
            wlen_next   = 4'd1;
          end else begin
            v1 = 1'b1;
            r1.error_code = bsl_pkg::E_BYTE;
          end
        end
      endcase
      if (mode_next != MODE_IDLE) tstart_next = off;
    end

    r0.last_of_run = !v1;
    r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      acc    <= '0;
      ovf    <= 1'b0;
      prefix <= '0;
      wlen   <= '0;
      line   <= 32'd1;
      off    <= '0;
      tstart <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      acc    <= acc_next;
      ovf    <= ovf_next;
      prefix <= prefix_next;
      wlen   <= wlen_next;
      line   <= line_next;
      off    <= off_next;
      tstart <= tstart_next;
    end
  end

  // output queue: up to two pushes and one pop per cycle
  assign pop         = tokens.valid && tokens.ready;
  assign bytes.ready = (count <= 3'd2);
  assign n_push      = accept ? (2'(v0) + 2'(v1)) : 2'd0;
  assign push_a      = v0 ? r0 : r1;
  assign push_b      = r1;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) queue[wr_ptr] <= push_a;
    if (n_push == 2'd2) queue[wr_ptr + 2'd1] <= push_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(n_push) - 3'(pop);
    end
  end

  assign tokens.valid        = (count != 3'd0);
  assign tokens.kind         = queue[rd_ptr].kind;
  assign tokens.error_code   = queue[rd_ptr].error_code;
  assign tokens.number_value = queue[rd_ptr].number_value;
  assign tokens.line_number  = queue[rd_ptr].line_number;
  assign tokens.start_offset = queue[rd_ptr].start_offset;
  assign tokens.end_offset   = queue[rd_ptr].end_offset;
  assign tokens.last_of_run  = queue[rd_ptr].last_of_run;

endmodule

### sim/tb.sv
// Self-checking testbench for the byte stream lexer: predicts tokens per source byte and compares.
`timescale 1ns / 1ps

module tb;
  import bsl_pkg::*;

  localparam int RANDOM_BYTES  = 2000;
  localparam int DRAIN_AT      = 1200;
  localparam int HOLD_AT       = 700;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_EQ, SCAN_BANG,
    SCAN_LT, SCAN_GT, SCAN_AMP, SCAN_PIPE
  } scan_e;

  logic clk;
  logic rst;

  bsl_byte_if  byte_ch ();
  bsl_token_if tok_ch ();

  byte_stream_lexer_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .tokens (tok_ch)
  );

  always #5 clk = ~clk;

  // scanner copy
  scan_e       mode;
  logic [30:0] acc;
  logic        ovf;
  logic [7:0]  prefix [KEYWORD_BYTES];
  logic [3:0]  wlen;
  logic [31:0] line_no;
  offset_t     boff;
  offset_t     tstart;

  logic [7:0] source_text [$];
  token_t     lexed_tokens [$];
  token_t     step_out [$];

  string kw_words [8] = '{"true", "false", "function", "let", "if", "else", "while", "return"};
  string op_words [23] = '{"+", "-", "*", "/", "==", "=", "!=", "<=", "<", ">=", ">", "&&",
                           "&", "||", "|", ":", ",", "(", ")", "{", "}", ";", "!"};

  int bytes_in, bytes_offered, total_bytes;
  int tokens_seen, eof_seen, errors_seen, fail_count;
  int burst_left, gap_left;
  bit drain_wait, drained;
  int hold_left, pattern_left, ready_pct;
  bit hold_done;
  int idle_cycles;
  token_t want;

  function automatic offset_t bump(input offset_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [5:0] classify_word();
    string w;
    bit    same;
    for (int k = 0; k < 8; k++) begin
      w = kw_words[k];
      same = (wlen == w.len());
      for (int i = 0; i < w.len(); i++) begin
        if (prefix[i] != w[i]) same = 0;
      end
      if (same) return K_KW0 + 6'(k);
    end
    return K_IDENT;
  endfunction

  task automatic emit_token(input logic [5:0] kind, input logic [1:0] err,
                            input logic [30:0] val, input offset_t s, input offset_t e);
    token_t t;
    t.kind         = kind;
    t.error_code   = err;
    t.number_value = val;
    t.line_number  = line_no;
    t.start_offset = 32'(s);
    t.end_offset   = 32'(e);
    t.last_of_run  = 1'b0;
    step_out.push_back(t);
  endtask

  task automatic reset_scanner();
    mode    = SCAN_IDLE;
    acc     = '0;
    ovf     = 1'b0;
    foreach (prefix[i]) prefix[i] = 8'h00;
    wlen    = '0;
    line_no = 32'd1;
    boff    = '0;
    tstart  = '0;
  endtask

  task automatic lex_byte(input logic [7:0] b);
    logic [34:0] v;
    bit          consumed;
    offset_t     s, e;
    logic [7:0]  pair_ch;
    logic [5:0]  pair_k, lone_k, single_k;
    bit          has_single;
    consumed = 0;
    has_single = 0;
    single_k = K_PLUS;
    pair_ch = 8'h00;
    pair_k = K_PLUS;
    lone_k = K_PLUS;
    step_out.delete();
    case (mode)
      SCAN_NUM: begin
        if (is_digit(b)) begin
          v = 35'(acc) * 35'd10 + 35'(b - 8'd48);
          if (ovf || v > 35'(NUM_MAX)) ovf = 1'b1;
          else acc = v[30:0];
          boff = bump(boff);
          consumed = 1;
        end else begin
          if (ovf) emit_token(K_NUM, E_OVERFLOW, '0, tstart, boff);
          else emit_token(K_NUM, E_NONE, acc, tstart, boff);
          mode = SCAN_IDLE;
        end
      end
      SCAN_WORD: begin
        if (is_alpha(b) || is_digit(b)) begin
          if (wlen < KEYWORD_BYTES) prefix[wlen] = b;
          if (wlen < 4'd15) wlen = wlen + 1'b1;
          boff = bump(boff);
          consumed = 1;
        end else begin
          emit_token(classify_word(), E_NONE, '0, tstart, boff);
          mode = SCAN_IDLE;
        end
      end
      SCAN_EQ, SCAN_BANG, SCAN_LT, SCAN_GT, SCAN_AMP, SCAN_PIPE: begin
        case (mode)
          SCAN_EQ:   begin pair_ch = "="; pair_k = K_EQEQ;   lone_k = K_EQ;  end
          SCAN_BANG: begin pair_ch = "="; pair_k = K_BANGEQ; lone_k = K_PLUS; end
          SCAN_LT:   begin pair_ch = "="; pair_k = K_LTEQ;   lone_k = K_LT;  end
          SCAN_GT:   begin pair_ch = "="; pair_k = K_GTEQ;   lone_k = K_GT;  end
          SCAN_AMP:  begin pair_ch = "&"; pair_k = K_ANDAND; lone_k = K_AND; end
          default:   begin pair_ch = "|"; pair_k = K_OROR;   lone_k = K_OR;  end
        endcase
        if (b == pair_ch) begin
          e = bump(boff);
          emit_token(pair_k, E_NONE, '0, tstart, e);
          boff = e;
          consumed = 1;
        end else if (mode == SCAN_BANG) begin
          emit_token(K_PLUS, E_BANG, '0, tstart, boff);
        end else begin
          emit_token(lone_k, E_NONE, '0, tstart, boff);
        end
        mode = SCAN_IDLE;
      end
      default: mode = SCAN_IDLE;
    endcase

    // byte not absorbed by a pending token: scan it from idle
    if (!consumed) begin
      s = boff;
      e = bump(boff);
      case (b)
        8'h00: begin
          emit_token(K_EOF, E_NONE, '0, s, e);
          line_no = 32'd1;
          e = '0;
        end
        "+": begin has_single = 1; single_k = K_PLUS;   end
        "-": begin has_single = 1; single_k = K_MINUS;  end
        "*": begin has_single = 1; single_k = K_STAR;   end
        "/": begin has_single = 1; single_k = K_SLASH;  end
        ":": begin has_single = 1; single_k = K_COLON;  end
        ",": begin has_single = 1; single_k = K_COMMA;  end
        "(": begin has_single = 1; single_k = K_LPAREN; end
        ")": begin has_single = 1; single_k = K_RPAREN; end
        "{": begin has_single = 1; single_k = K_LBRACE; end
        "}": begin has_single = 1; single_k = K_RBRACE; end
        ";": begin has_single = 1; single_k = K_SEMI;   end
        "=": mode = SCAN_EQ;
        "!": mode = SCAN_BANG;
        "<": mode = SCAN_LT;
        ">": mode = SCAN_GT;
        "&": mode = SCAN_AMP;
        "|": mode = SCAN_PIPE;
        default: begin
          if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
            if (b == 8'd10 && line_no != '1) line_no = line_no + 1'b1;
          end else if (is_digit(b)) begin
            mode = SCAN_NUM;
            acc  = 31'(b - 8'd48);
            ovf  = 1'b0;
          end else if (is_alpha(b)) begin
            mode = SCAN_WORD;
            foreach (prefix[i]) prefix[i] = 8'h00;
            prefix[0] = b;
            wlen = 4'd1;
          end else begin
            emit_token(K_PLUS, E_BYTE, '0, s, e);
          end
        end
      endcase
      if (has_single) emit_token(single_k, E_NONE, '0, s, e);
      if (mode != SCAN_IDLE) tstart = s;
      boff = e;
    end

    if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
    foreach (step_out[i]) lexed_tokens.push_back(step_out[i]);
  endtask

  task automatic push_text(input string txt);
    for (int i = 0; i < txt.len(); i++) source_text.push_back(txt[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 4) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
  endfunction

  task automatic fill_random(input int count);
    int    r, len, ws, stop;
    string big_nums [5] = '{"2147483647", "2147483648", "4294967296", "99999999999", "000123"};
    stop = source_text.size() + count;
    while (source_text.size() < stop) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        push_text(kw_words[$urandom_range(0, 7)]);
        if ($urandom_range(0, 3) == 0) source_text.push_back(rand_alnum());
      end else if (r < 24) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        source_text.push_back(rand_letter());
        for (int i = 1; i < len; i++) source_text.push_back(rand_alnum());
      end else if (r < 38) begin
        if ($urandom_range(0, 5) == 0) begin
          push_text(big_nums[$urandom_range(0, 4)]);
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) source_text.push_back(8'("0" + $urandom_range(0, 9)));
        end
      end else if (r < 62) begin
        push_text(op_words[$urandom_range(0, 22)]);
      end else if (r < 94) begin
        ws = $urandom_range(9, 14);
        source_text.push_back((ws == 14) ? 8'd32 : 8'(ws));
      end else if (r < 98) begin
        source_text.push_back(8'($urandom_range(1, 255)));
      end else begin
        source_text.push_back(8'h00);
      end
    end
    // flush whatever is pending
    source_text.push_back(8'h00);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // token checker and byte predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (tok_ch.valid && tok_ch.ready) begin
        tokens_seen++;
        if (lexed_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, actual kind %0d at %0d",
                   $time, tok_ch.kind, tok_ch.start_offset);
          fail_count++;
        end else begin
          want = lexed_tokens.pop_front();
          if (want.kind == K_EOF) eof_seen++;
          if (want.error_code != E_NONE) errors_seen++;
          check_field("kind", 32'(want.kind), 32'(tok_ch.kind));
          check_field("error_code", 32'(want.error_code), 32'(tok_ch.error_code));
          check_field("number_value", 32'(want.number_value), 32'(tok_ch.number_value));
          check_field("line_number", want.line_number, tok_ch.line_number);
          check_field("start_offset", want.start_offset, tok_ch.start_offset);
          check_field("end_offset", want.end_offset, tok_ch.end_offset);
          check_field("last_of_run", 32'(want.last_of_run), 32'(tok_ch.last_of_run));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        lex_byte(byte_ch.source_byte);
        bytes_in++;
      end
    end
  end

  // byte driver: bursts with gaps, one drain pause
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid       <= 1'b0;
      byte_ch.source_byte <= 8'h00;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        byte_ch.valid <= 1'b0;
      end else if (bytes_offered == DRAIN_AT && !drained) begin
        // hold until every outstanding token has come back
        byte_ch.valid <= 1'b0;
        if (drain_wait && lexed_tokens.size() == 0) drained = 1;
        drain_wait = 1;
      end else if (source_text.size() == 0) begin
        byte_ch.valid <= 1'b0;
      end else begin
        byte_ch.valid       <= 1'b1;
        byte_ch.source_byte <= source_text.pop_front();
        bytes_offered++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // token receiver: changing stall density, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      tok_ch.ready <= 1'b0;
    end else begin
      if (!hold_done && bytes_in >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        tok_ch.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 50;
            2: ready_pct = 90;
            default: ready_pct = 25;
          endcase
          pattern_left = $urandom_range(16, 128);
        end else begin
          pattern_left--;
        end
        tok_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d tokens outstanding",
                 $time, IDLE_LIMIT, lexed_tokens.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.source_byte = 8'h00;
    tok_ch.ready        = 1'b0;
    reset_scanner();

    // overflowing number, lone bang, flushed word, keyword, pair, bad byte, newline, eof
    push_text("2147483648!x;return==");
    source_text.push_back(8'hFF);
    source_text.push_back(8'd10);
    source_text.push_back(8'h00);
    fill_random(RANDOM_BYTES);
    total_bytes = source_text.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (bytes_in < total_bytes || lexed_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Lexed %0d source bytes into %0d tokens (%0d eof, %0d error-coded).",
             bytes_in, tokens_seen, eof_seen, errors_seen);
    $display("Random burst/gap traffic, a long token hold-off and a full drain pause included.");
    if (fail_count == 0 && lexed_tokens.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d tokens never arrived", fail_count, lexed_tokens.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
